/* rtl/core/prc_pkg.sv */
package prc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SEED_W     = 16;
  localparam int unsigned GEN_W      = 17;
  localparam int unsigned PROD_W     = 23;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ROT_W      = 7;

  localparam logic [6:0]        GEN_MULT    = 7'd75;
  localparam logic [GEN_W-1:0]  GEN_MOD     = 17'd65537;
  localparam logic [GEN_W-1:0]  GEN_RESET   = 17'd1;
  localparam logic [BYTE_W-1:0] PRINT_FIRST = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_END   = 8'd128;
  localparam logic [ROT_W:0]    PRINT_COUNT = 8'd96;

  // reciprocal of 3 scaled by 2^13, exact floor for values below 4096
  localparam logic [11:0] RECIP3 = 12'd2731;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECRYPT_MODE = 2'd0,
    REG_INITIAL_SEED = 2'd1
  } cfg_reg_t;

endpackage

/* rtl/core/prng_rotation_stream_cipher.sv */
// Byte stream cipher: every accepted beat advances a Lehmer generator
// (g = g*75 mod 65537, reset to 1) and a byte in 32..127 is rotated within
// those 96 codes by g mod 96, forward when decrypt_mode is 0 and backward
// when it is 1; other bytes pass unchanged while the generator still steps.
// One beat is taken every cycle while the output is not stalled; a beat's
// result passes through the input register, holding the byte with the new
// generator value, and then the output register after the rotation.
// Register 0 is decrypt_mode, register 1 is the seed, and a seed write
// reloads the generator. Write registers only while no beat is in flight.
module prng_rotation_stream_cipher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prc_pkg::SEED_W-1:0]       cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [prc_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] data_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [prc_pkg::BYTE_W-1:0]       m_axis_tdata   // [7:0] out_byte
);
  import prc_pkg::*;

  logic              decrypt_mode;
  logic [GEN_W-1:0]  gen;
  logic [GEN_W-1:0]  gen_next;
  logic [PROD_W-1:0] prod;
  logic [15:0]       prod_lo;
  logic [6:0]        prod_hi;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic [GEN_W-1:0]  in_gen;

  logic              out_load;
  logic              in_load;
  logic              cfg_wr;

  logic [11:0]       amt_hi;
  logic [23:0]       q_prod;
  logic [10:0]       q3;
  logic [1:0]        r3;
  logic [ROT_W-1:0]  amount;
  logic [ROT_W-1:0]  pos;
  logic [ROT_W:0]    rot_sum;
  logic [ROT_W:0]    rot_fix;
  logic              printable;
  logic [BYTE_W-1:0] out_next;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign out_load      = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // generator step
  always_comb begin
    prod    = {6'd0, gen} * {16'd0, GEN_MULT};
    prod_lo = prod[15:0];
    prod_hi = prod[22:16];
    if (prod_lo >= {9'd0, prod_hi}) begin
      gen_next = {1'b0, prod_lo} - {10'd0, prod_hi};
    end else begin
      gen_next = {1'b0, prod_lo} + GEN_MOD - {10'd0, prod_hi};
    end
  end

  // rotation amount = gen mod 96 = (gen[16:5] mod 3) * 32 + gen[4:0]
  always_comb begin
    amt_hi  = in_gen[16:5];
    q_prod  = {12'd0, amt_hi} * {12'd0, RECIP3};
    q3      = q_prod[23:13];
    r3      = 2'(amt_hi - 12'(q3 * 2'd3));
    amount  = {r3, in_gen[4:0]};
    printable = (in_byte >= PRINT_FIRST) && (in_byte < PRINT_END);
    pos     = ROT_W'(in_byte - PRINT_FIRST);
    if (decrypt_mode) begin
      rot_sum = {1'b0, pos} + PRINT_COUNT - {1'b0, amount};
    end else begin
      rot_sum = {1'b0, pos} + {1'b0, amount};
    end
    if (rot_sum >= PRINT_COUNT) begin
      rot_fix = rot_sum - PRINT_COUNT;
    end else begin
      rot_fix = rot_sum;
    end
    if (printable) begin
      out_next = rot_fix + PRINT_FIRST;
    end else begin
      out_next = in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode  <= 1'b0;
      gen           <= GEN_RESET;
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
          REG_INITIAL_SEED: gen          <= {1'b0, cfg_data};
          default: ;
        endcase
      end
      if (in_load && !(cfg_wr && cfg_index == REG_INITIAL_SEED)) begin
        gen <= gen_next;
      end
      if (in_load) begin
        in_valid <= 1'b1;
      end else if (out_load) begin
        in_valid <= 1'b0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_byte <= s_axis_tdata;
      in_gen  <= gen_next;
    end
    if (out_load) begin
      m_axis_tdata <= out_next;
    end
  end

  a_gen_range: assert property (@(posedge clk) disable iff (rst)
    gen <= 17'h10000)
    else $error("generator out of range");

  a_amount_range: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> {1'b0, amount} < PRINT_COUNT)
    else $error("rotation amount out of range");

  a_class_kept: assert property (@(posedge clk) disable iff (rst)
    out_load |=> ((m_axis_tdata >= PRINT_FIRST && m_axis_tdata < PRINT_END) ==
                  ($past(in_byte) >= PRINT_FIRST && $past(in_byte) < PRINT_END)))
    else $error("printable class changed");

  a_seed_load: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg_index == REG_INITIAL_SEED) |=> gen == {1'b0, $past(cfg_data)})
    else $error("seed write did not load generator");

endmodule
